>>> sv/zcdw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package zcdw_pkg;

  localparam logic [31:0] CD_MAGIC      = 32'h02014b50;
  localparam int          CD_HEADER_LEN = 46;

  // Header byte positions of the captured fields
  localparam logic [5:0] SIG_FIRST     = 6'd0;
  localparam logic [5:0] CRC_FIRST     = 6'd16;
  localparam logic [5:0] SIZE_FIRST    = 6'd20;
  localparam logic [5:0] NLEN_FIRST    = 6'd28;
  localparam logic [5:0] XLEN_FIRST    = 6'd30;
  localparam logic [5:0] CLEN_FIRST    = 6'd32;
  localparam logic [5:0] OFFSET_FIRST  = 6'd42;
  localparam logic [5:0] HEADER_LAST   = 6'(CD_HEADER_LEN - 1);

  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_NAME  = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_NAME   = 2'd1,
    PH_SKIP   = 2'd2,
    PH_STOP   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } zcdw_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] entry_crc;
    logic [31:0] compressed_bytes;
    logic [31:0] local_header_offset;
    logic [15:0] name_length;
    logic [7:0]  name_byte;
    logic        name_last;
  } zcdw_out_t;

endpackage
`default_nettype wire

>>> sv/zcdw_parser.sv
`timescale 1ns / 1ps
`default_nettype none
module zcdw_parser (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 take,
  input  zcdw_pkg::zcdw_in_t  item,
  output logic                res_valid,
  output zcdw_pkg::zcdw_out_t res
);
  import zcdw_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  logic [5:0]  header_byte_index;
  logic [5:0]  header_byte_index_next;
  logic [17:0] bytes_left;
  logic [17:0] bytes_left_next;
  logic [31:0] signature_word, signature_word_next;
  logic [31:0] crc_word, crc_word_next;
  logic [31:0] size_word, size_word_next;
  logic [31:0] offset_word, offset_word_next;
  logic [15:0] name_len_word, name_len_word_next;
  logic [15:0] extra_len_word, extra_len_word_next;
  logic [15:0] comment_len_word, comment_len_word_next;

  logic [7:0]  b;
  logic [5:0]  i;
  logic [17:0] bl_dec;
  logic [17:0] skip_len;

  assign b        = item.data_byte;
  assign i        = header_byte_index;
  assign bl_dec   = (bytes_left != '0) ? bytes_left - 18'd1 : '0;
  assign skip_len = {1'b0, 17'(extra_len_word) + 17'(comment_len_word)};

  // Field capture: shift bytes in little-endian
  always_comb begin
    signature_word_next   = signature_word;
    crc_word_next         = crc_word;
    size_word_next        = size_word;
    offset_word_next      = offset_word;
    name_len_word_next    = name_len_word;
    extra_len_word_next   = extra_len_word;
    comment_len_word_next = comment_len_word;
    if (phase == PH_HEADER) begin
      if (i < CRC_FIRST && i < SIG_FIRST + 6'd4) begin
        signature_word_next = {b, signature_word[31:8]};
      end else if (i >= CRC_FIRST && i < SIZE_FIRST) begin
        crc_word_next = {b, crc_word[31:8]};
      end else if (i >= SIZE_FIRST && i < SIZE_FIRST + 6'd4) begin
        size_word_next = {b, size_word[31:8]};
      end else if (i >= NLEN_FIRST && i < XLEN_FIRST) begin
        name_len_word_next = {b, name_len_word[15:8]};
      end else if (i >= XLEN_FIRST && i < CLEN_FIRST) begin
        extra_len_word_next = {b, extra_len_word[15:8]};
      end else if (i >= CLEN_FIRST && i < CLEN_FIRST + 6'd2) begin
        comment_len_word_next = {b, comment_len_word[15:8]};
      end else if (i >= OFFSET_FIRST) begin
        offset_word_next = {b, offset_word[31:8]};
      end
    end
  end

  // Next control state
  always_comb begin
    phase_next             = phase;
    header_byte_index_next = header_byte_index;
    bytes_left_next        = bytes_left;
    unique case (phase)
      PH_HEADER: begin
        if (i == HEADER_LAST) begin
          header_byte_index_next = '0;
          if (signature_word_next != CD_MAGIC) begin
            phase_next = PH_STOP;
          end else if (name_len_word_next != '0) begin
            bytes_left_next = {2'b00, name_len_word_next};
            phase_next      = PH_NAME;
          end else begin
            bytes_left_next = skip_len;
            phase_next      = (skip_len != '0) ? PH_SKIP : PH_HEADER;
          end
        end else begin
          header_byte_index_next = i + 6'd1;
        end
      end
      PH_NAME: begin
        bytes_left_next = bl_dec;
        if (bl_dec == '0) begin
          bytes_left_next = skip_len;
          phase_next      = (skip_len != '0) ? PH_SKIP : PH_HEADER;
        end
      end
      PH_SKIP: begin
        bytes_left_next = bl_dec;
        if (bl_dec == '0) begin
          phase_next = PH_HEADER;
        end
      end
      PH_STOP: begin
        phase_next = PH_STOP;
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase
    if (item.buffer_end) begin
      phase_next             = PH_HEADER;
      header_byte_index_next = '0;
      bytes_left_next        = '0;
    end
  end

  // Result for this byte
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    unique case (phase)
      PH_HEADER: begin
        if (i == HEADER_LAST) begin
          res_valid = 1'b1;
          if (signature_word_next != CD_MAGIC) begin
            res.kind = KIND_STOP;
          end else begin
            res.kind                = KIND_ENTRY;
            res.entry_crc           = crc_word_next;
            res.compressed_bytes    = size_word_next;
            res.local_header_offset = offset_word_next;
            res.name_length         = name_len_word_next;
          end
        end
      end
      PH_NAME: begin
        res_valid     = 1'b1;
        res.kind      = KIND_NAME;
        res.name_byte = b;
        res.name_last = (bl_dec == '0) || item.buffer_end;
      end
      PH_SKIP, PH_STOP: begin
        res_valid = 1'b0;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      header_byte_index <= '0;
      bytes_left        <= '0;
    end else if (take) begin
      phase             <= phase_next;
      header_byte_index <= header_byte_index_next;
      bytes_left        <= bytes_left_next;
    end
  end

  // Header fields are fully rewritten by every header, so no reset
  always_ff @(posedge clk) begin
    if (take) begin
      signature_word   <= signature_word_next;
      crc_word         <= crc_word_next;
      size_word        <= size_word_next;
      offset_word      <= offset_word_next;
      name_len_word    <= name_len_word_next;
      extra_len_word   <= extra_len_word_next;
      comment_len_word <= comment_len_word_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/zcdw_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
module zcdw_out_buf (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  zcdw_pkg::zcdw_out_t push_data,
  output logic                has_room,
  output logic                out_valid,
  input  wire                 out_ready,
  output zcdw_pkg::zcdw_out_t out_data
);
  import zcdw_pkg::*;

  zcdw_out_t   slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic [1:0]  count_next;
  logic        pop;

  assign pop       = out_valid && out_ready;
  assign has_room  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> sv/zip_central_directory_walker.sv
// ZIP central directory walker.
// Input channel (in_valid/in_ready/in_data): one directory byte per transfer,
// with buffer_end set on the final byte of the directory.
// Output channel (out_valid/out_ready/out_data): entry results (CRC, size,
// local header offset, name length), one result per name byte, or a stop
// result on a bad record signature. Extra and comment bytes give nothing.
// Latency: a result is visible on out_valid the cycle after the byte that
// causes it is transferred in.
// Throughput: one byte per cycle while the output buffer has room; the parser
// state updates once per byte and the result lands in a two-entry output buffer.
// When the receiver stalls, up to two results are held; in_ready drops only
// when both buffer entries are full, and rises again as soon as one drains.
// Reset (rst, synchronous) empties the buffer and puts the parser into header
// gathering. The byte carrying buffer_end also returns the parser to header
// gathering; a header cut short by it is dropped.
`timescale 1ns / 1ps
`default_nettype none
module zip_central_directory_walker (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  zcdw_pkg::zcdw_in_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output zcdw_pkg::zcdw_out_t out_data
);
  import zcdw_pkg::*;

  logic      take;
  logic      res_valid;
  zcdw_out_t res;
  logic      has_room;

  // Advance the parser on every input transfer
  assign in_ready = has_room;
  assign take     = in_valid && in_ready;

  zcdw_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (in_data),
    .res_valid (res_valid),
    .res       (res)
  );

  // Hold results here while the receiver stalls
  zcdw_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (take && res_valid),
    .push_data (res),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> dv/zcdw_checker.sv
`timescale 1ns / 1ps
module zcdw_checker (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  wire                 in_ready,
  input  zcdw_pkg::zcdw_in_t  in_data,
  input  wire                 out_valid,
  input  wire                 out_ready,
  input  zcdw_pkg::zcdw_out_t out_data,
  output int                  mismatches,
  output int                  waiting
);
  import zcdw_pkg::*;

  // Parser state mirrored from the directory byte stream
  phase_t      ph;
  logic [5:0]  hdr_idx;
  logic [31:0] sig_w;
  logic [31:0] crc_w;
  logic [31:0] size_w;
  logic [31:0] ofs_w;
  logic [15:0] nlen_w;
  logic [15:0] xlen_w;
  logic [15:0] clen_w;
  logic [17:0] left;

  zcdw_out_t cd_results_due[$];
  zcdw_out_t want;
  int        results_seen = 0;

  task automatic clear_walk;
    ph      = PH_HEADER;
    hdr_idx = '0;
    sig_w   = '0;
    crc_w   = '0;
    size_w  = '0;
    ofs_w   = '0;
    nlen_w  = '0;
    xlen_w  = '0;
    clen_w  = '0;
    left    = '0;
  endtask

  task automatic walk_directory_byte(input zcdw_in_t b);
    zcdw_out_t r;
    logic      emit;
    r    = '0;
    emit = 1'b0;
    case (ph)
      PH_HEADER: begin
        // Capture little-endian fields as their bytes go by
        if (hdr_idx >= SIG_FIRST && hdr_idx < SIG_FIRST + 4)
          sig_w = {b.data_byte, sig_w[31:8]};
        else if (hdr_idx >= CRC_FIRST && hdr_idx < CRC_FIRST + 4)
          crc_w = {b.data_byte, crc_w[31:8]};
        else if (hdr_idx >= SIZE_FIRST && hdr_idx < SIZE_FIRST + 4)
          size_w = {b.data_byte, size_w[31:8]};
        else if (hdr_idx >= NLEN_FIRST && hdr_idx < NLEN_FIRST + 2)
          nlen_w = {b.data_byte, nlen_w[15:8]};
        else if (hdr_idx >= XLEN_FIRST && hdr_idx < XLEN_FIRST + 2)
          xlen_w = {b.data_byte, xlen_w[15:8]};
        else if (hdr_idx >= CLEN_FIRST && hdr_idx < CLEN_FIRST + 2)
          clen_w = {b.data_byte, clen_w[15:8]};
        else if (hdr_idx >= OFFSET_FIRST && hdr_idx < OFFSET_FIRST + 4)
          ofs_w = {b.data_byte, ofs_w[31:8]};
        if (hdr_idx == HEADER_LAST) begin
          hdr_idx = '0;
          emit    = 1'b1;
          if (sig_w != CD_MAGIC) begin
            r.kind = KIND_STOP;
            ph     = PH_STOP;
          end else begin
            r.kind                = KIND_ENTRY;
            r.entry_crc           = crc_w;
            r.compressed_bytes    = size_w;
            r.local_header_offset = ofs_w;
            r.name_length         = nlen_w;
            if (nlen_w != 0) begin
              left = 18'(nlen_w);
              ph   = PH_NAME;
            end else begin
              left = 18'(xlen_w) + 18'(clen_w);
              ph   = (left != 0) ? PH_SKIP : PH_HEADER;
            end
          end
        end else begin
          hdr_idx = hdr_idx + 1'b1;
        end
      end
      PH_NAME: begin
        if (left != 0) left = left - 1'b1;
        emit        = 1'b1;
        r.kind      = KIND_NAME;
        r.name_byte = b.data_byte;
        r.name_last = (left == 0) || b.buffer_end;
        if (left == 0) begin
          left = 18'(xlen_w) + 18'(clen_w);
          ph   = (left != 0) ? PH_SKIP : PH_HEADER;
        end
      end
      PH_SKIP: begin
        if (left != 0) left = left - 1'b1;
        if (left == 0) ph = PH_HEADER;
      end
      default: begin
      end
    endcase
    if (b.buffer_end) clear_walk();
    if (emit) cd_results_due.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_walk();
      cd_results_due.delete();
    end else begin
      // Compare before predicting: a result never leaves in the cycle of its byte
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (cd_results_due.size() == 0) begin
          if (mismatches < 10)
            $display("result %0d not expected: kind %0d crc %h size %h ofs %h nlen %h byte %h last %b",
                     results_seen, out_data.kind, out_data.entry_crc,
                     out_data.compressed_bytes, out_data.local_header_offset,
                     out_data.name_length, out_data.name_byte, out_data.name_last);
          mismatches <= mismatches + 1;
        end else begin
          want = cd_results_due.pop_front();
          if (out_data.kind !== want.kind ||
              out_data.entry_crc !== want.entry_crc ||
              out_data.compressed_bytes !== want.compressed_bytes ||
              out_data.local_header_offset !== want.local_header_offset ||
              out_data.name_length !== want.name_length ||
              out_data.name_byte !== want.name_byte ||
              out_data.name_last !== want.name_last) begin
            if (mismatches < 10) begin
              $display("result %0d exp kind %0d crc %h size %h ofs %h nlen %h byte %h last %b",
                       results_seen, want.kind, want.entry_crc, want.compressed_bytes,
                       want.local_header_offset, want.name_length, want.name_byte,
                       want.name_last);
              $display("result %0d got kind %0d crc %h size %h ofs %h nlen %h byte %h last %b",
                       results_seen, out_data.kind, out_data.entry_crc,
                       out_data.compressed_bytes, out_data.local_header_offset,
                       out_data.name_length, out_data.name_byte, out_data.name_last);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && in_ready) walk_directory_byte(in_data);
    end
    waiting <= cd_results_due.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import zcdw_pkg::*;

  // The run ends with a mismatch once the cycle count reaches CYCLE_LIMIT
  localparam int CYCLE_LIMIT = 400000;
  localparam int TOTAL_BYTES = 1100;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  zcdw_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  zcdw_out_t out_data;

  logic      in_took = 1'b0;   // input transfer seen at the last rising edge
  bit        quiet = 1'b0;     // suppress idling on both sides
  int        cycles = 0;
  int        bytes_sent = 0;
  int        mismatches;
  int        waiting;
  logic [7:0] dir_bytes[$];    // directory being assembled for the next send

  always #2 clk = ~clk;

  zip_central_directory_walker u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  zcdw_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .waiting    (waiting)
  );

  // Register the handshake so the stimulus can act on it at the falling edge
  always @(posedge clk) begin
    in_took <= in_valid && in_ready;
    cycles  <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("zip_central_directory_walker: mismatch");
      $finish;
    end
  end

  // Receiver: stall with a chance of 37 in a hundred, never during a quiet stretch
  always @(negedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 37);
  end

  // Offer one byte, possibly after a random gap, and hold it until transferred.
  // Each cycle idles with a chance of 37 in a hundred. Entered and left at a
  // falling edge.
  task automatic transfer_byte(input logic [7:0] d, input logic last);
    int gap;
    gap = 0;
    while (!quiet && $urandom_range(99) < 37) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid             <= 1'b1;
    in_data.data_byte    <= d;
    in_data.buffer_end   <= last;
    do @(negedge clk); while (!in_took);
  endtask

  // Append one 46-byte record header, filler bytes random, followed by at most
  // body_cap bytes of name, extra field and comment.
  task automatic add_record(input logic [31:0] sig, input logic [31:0] crc,
                            input logic [31:0] size, input logic [31:0] ofs,
                            input logic [15:0] nlen, input logic [15:0] xlen,
                            input logic [15:0] clen, input int body_cap);
    logic [CD_HEADER_LEN*8-1:0] hdr;
    int body;
    for (int p = 0; p < CD_HEADER_LEN; p++) hdr[p*8 +: 8] = 8'($urandom);
    hdr[SIG_FIRST*8 +: 32]    = sig;
    hdr[CRC_FIRST*8 +: 32]    = crc;
    hdr[SIZE_FIRST*8 +: 32]   = size;
    hdr[NLEN_FIRST*8 +: 16]   = nlen;
    hdr[XLEN_FIRST*8 +: 16]   = xlen;
    hdr[CLEN_FIRST*8 +: 16]   = clen;
    hdr[OFFSET_FIRST*8 +: 32] = ofs;
    for (int p = 0; p < CD_HEADER_LEN; p++) dir_bytes.push_back(hdr[p*8 +: 8]);
    body = int'(nlen) + int'(xlen) + int'(clen);
    if (body > body_cap) body = body_cap;
    repeat (body) dir_bytes.push_back(8'($urandom));
  endtask

  // Send the assembled directory with the end flag on its final byte
  task automatic send_directory;
    for (int i = 0; i < dir_bytes.size(); i++)
      transfer_byte(dir_bytes[i], i == dir_bytes.size() - 1);
    bytes_sent += dir_bytes.size();
    dir_bytes.delete();
  endtask

  // Drop valid and hold until every predicted result has been transferred out
  task automatic wait_drained;
    in_valid <= 1'b0;
    do @(negedge clk); while (waiting != 0);
  endtask

  initial begin
    logic [31:0] sig;
    logic [15:0] nlen;
    logic [15:0] xlen;
    logic [15:0] clen;
    int          records;
    int          cap;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Full entries: all-ones and all-zeros fields, single-byte name, empty name
    // straight to the next header, empty name followed by a skip, and the end
    // flag falling on the last comment byte.
    add_record(CD_MAGIC, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
               16'd3, 16'd2, 16'd1, 6);
    add_record(CD_MAGIC, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
               16'd0, 16'd0, 16'd0, 0);
    add_record(CD_MAGIC, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_F0F0,
               16'd0, 16'd3, 16'd0, 3);
    add_record(CD_MAGIC, $urandom, $urandom, $urandom, 16'd1, 16'd0, 16'd2, 3);
    send_directory();

    // Bad signature: stop result, then a good record that must be ignored
    add_record(~CD_MAGIC, $urandom, $urandom, $urandom, 16'd4, 16'd0, 16'd0, 4);
    add_record(CD_MAGIC, $urandom, $urandom, $urandom, 16'd2, 16'd0, 16'd0, 2);
    send_directory();

    // Bad signature one bit off, end flag on its last header byte
    add_record(CD_MAGIC ^ 32'h1, $urandom, $urandom, $urandom, 16'd0, 16'd0, 16'd0, 0);
    send_directory();

    // Header one byte short at the end flag: dropped
    add_record(CD_MAGIC, $urandom, $urandom, $urandom, 16'd0, 16'd0, 16'd0, 0);
    void'(dir_bytes.pop_back());
    send_directory();

    // Header completing on the end flag, with a name that never comes
    add_record(CD_MAGIC, $urandom, $urandom, $urandom, 16'd5, 16'd1, 16'd1, 0);
    send_directory();

    // Largest lengths, name cut short by the end flag
    add_record(CD_MAGIC, $urandom, $urandom, $urandom, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4);
    send_directory();

    // Extra and comment reaching past the end flag
    add_record(CD_MAGIC, $urandom, $urandom, $urandom, 16'd2, 16'hFFFF, 16'hFFFF, 9);
    send_directory();

    // Directory of a single byte
    dir_bytes.push_back(8'hFF);
    send_directory();

    wait_drained();

    // Random directories until the byte total is reached: mostly well-formed
    // records with random content, some truncated, some with bad signatures,
    // and some pure noise. The first few go without any idling.
    for (int d = 0; bytes_sent < TOTAL_BYTES; d++) begin
      quiet <= (d < 3);
      if (d == 2) wait_drained();
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 60)) dir_bytes.push_back(8'($urandom));
      end else begin
        records = $urandom_range(1, 4);
        for (int r = 0; r < records; r++) begin
          if ($urandom_range(99) < 88)
            sig = CD_MAGIC;
          else if ($urandom_range(1) == 1)
            sig = $urandom;
          else
            sig = CD_MAGIC ^ (32'h1 << $urandom_range(31));
          nlen = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(12));
          xlen = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(6));
          clen = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(6));
          cap  = int'(nlen) + int'(xlen) + int'(clen);
          // A huge record can only be cut short, so end the directory with it
          if (cap > 64) begin
            cap     = $urandom_range(20);
            records = r + 1;
          end
          add_record(sig, $urandom, $urandom, $urandom, nlen, xlen, clen, cap);
        end
        if ($urandom_range(4) == 0)
          repeat ($urandom_range(1, dir_bytes.size() - 1)) void'(dir_bytes.pop_back());
      end
      send_directory();
    end

    quiet <= 1'b0;
    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && waiting == 0) begin
      $display("zip_central_directory_walker: match");
    end else begin
      $display("zip_central_directory_walker: mismatch");
    end
    $finish;
  end

endmodule

>>> zip_central_directory_walker.f
sv/zcdw_pkg.sv
sv/zcdw_parser.sv
sv/zcdw_out_buf.sv
sv/zip_central_directory_walker.sv
dv/zcdw_checker.sv
dv/tb.sv
